// ===== sv/srrw_pkg.sv =====
`timescale 1ns / 1ps

package srrw_pkg;

  localparam int WINDOW_MAX  = 16;
  localparam int SEQ_MODULUS = 30000;
  localparam int SEQ_STEP    = 1024;
  localparam int HIST_WIN    = 15;
  localparam int HIST_SPAN   = HIST_WIN + SEQ_MODULUS / SEQ_STEP - 1;
  localparam int STEP_MOD    = SEQ_STEP % SEQ_MODULUS;
  localparam int HIST_BACK   = (HIST_SPAN * SEQ_STEP) % SEQ_MODULUS;

  localparam int SEQ_W   = 15;
  localparam int IDX_W   = 16;
  localparam int WS_W    = 5;
  localparam int TOT_W   = 16;
  localparam int REL_W   = 5;
  localparam int REPLY_W = 2;
  localparam int WIN_W   = $clog2(WINDOW_MAX + 1);
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 3;

  localparam int WS_RESET  = 15;
  localparam int WS_RESET_ACT = (WS_RESET < 1) ? 1 :
                                ((WS_RESET > WINDOW_MAX) ? WINDOW_MAX : WS_RESET);

  localparam logic REG_WINDOW = 1'b0;
  localparam logic REG_TOTAL  = 1'b1;

  typedef enum logic [REPLY_W-1:0] {
    REPLY_NONE = 2'd0,
    REPLY_ACK  = 2'd1,
    REPLY_RETX = 2'd2
  } reply_e;

  typedef struct packed {
    logic             valid;
    logic             acked;
    logic [SEQ_W-1:0] seq;
  } slot_t;

  typedef struct packed {
    logic restart;
    logic shift;
    logic mark;
  } cell_ctl_t;

  typedef struct packed {
    logic [WS_W-1:0]  window_size;
    logic [TOT_W-1:0] total_packets;
    logic             restart;
  } cfg_t;

  typedef logic [SEQ_W-1:0] seq_tab_t [WINDOW_MAX+1];

  function automatic logic [SEQ_W-1:0] seq_advance(input logic [SEQ_W-1:0] s);
    logic [SEQ_W:0] sum;
    sum = {1'b0, s} + (SEQ_W+1)'(STEP_MOD);
    if (sum >= (SEQ_W+1)'(SEQ_MODULUS)) begin
      sum = sum - (SEQ_W+1)'(SEQ_MODULUS);
    end
    return sum[SEQ_W-1:0];
  endfunction

  function automatic seq_tab_t build_seq_tab();
    seq_tab_t       t;
    logic [SEQ_W-1:0] s;
    s = '0;
    for (int k = 0; k <= WINDOW_MAX; k++) begin
      t[k] = s;
      s = seq_advance(s);
    end
    return t;
  endfunction

  localparam seq_tab_t SEQ_TAB = build_seq_tab();

  function automatic logic [WIN_W-1:0] active_window(input logic [WS_W-1:0] ws);
    logic [WIN_W-1:0] w;
    if (ws == '0) begin
      w = WIN_W'(1);
    end else if ((WIN_W > WS_W ? WIN_W : WS_W)'(ws) >
                 (WIN_W > WS_W ? WIN_W : WS_W)'(WINDOW_MAX)) begin
      w = WIN_W'(WINDOW_MAX);
    end else begin
      w = WIN_W'(ws);
    end
    return w;
  endfunction

endpackage

// ===== sv/srrw_if.sv =====
`timescale 1ns / 1ps

interface srrw_in_if;
  import srrw_pkg::*;
  logic             valid;
  logic             ready;
  logic             kind;
  logic [SEQ_W-1:0] seq_num;

  modport source (output valid, output kind, output seq_num, input ready);
  modport sink   (input valid, input kind, input seq_num, output ready);
endinterface

interface srrw_out_if;
  import srrw_pkg::*;
  logic               valid;
  logic               ready;
  logic [REPLY_W-1:0] reply;
  logic [SEQ_W-1:0]   reply_seq;
  logic [REL_W-1:0]   released;
  logic               all_received;

  modport source (output valid, output reply, output reply_seq, output released,
                  output all_received, input ready);
  modport sink   (input valid, input reply, input reply_seq, input released,
                  input all_received, output ready);
endinterface

// ===== sv/srrw_cfg.sv =====
`timescale 1ns / 1ps

module srrw_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [srrw_pkg::ADDR_W-1:0]  paddr,
  input  logic [srrw_pkg::DATA_W-1:0]  pwdata,
  output logic [srrw_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output srrw_pkg::cfg_t               cfg_o
);
  import srrw_pkg::*;

  logic [WS_W-1:0]  ws_q, ws_d;
  logic [TOT_W-1:0] tot_q, tot_d;
  logic             restart_q, restart_d;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    ws_d      = ws_q;
    tot_d     = tot_q;
    restart_d = wr_en;
    if (wr_en) begin
      unique case (paddr[2])
        REG_WINDOW: ws_d  = pwdata[WS_W-1:0];
        REG_TOTAL:  tot_d = pwdata[TOT_W-1:0];
        default:    ws_d  = ws_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_WINDOW: prdata = DATA_W'(ws_q);
      REG_TOTAL:  prdata = DATA_W'(tot_q);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_q      <= WS_W'(WS_RESET);
      tot_q     <= '0;
      restart_q <= 1'b0;
    end else begin
      ws_q      <= ws_d;
      tot_q     <= tot_d;
      restart_q <= restart_d;
    end
  end

  assign cfg_o = '{window_size: ws_q, total_packets: tot_q, restart: restart_q};

endmodule

// ===== sv/srrw_cell.sv =====
`timescale 1ns / 1ps

module srrw_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  srrw_pkg::cell_ctl_t         ctl_i,
  input  srrw_pkg::slot_t             init_i,
  input  srrw_pkg::slot_t             next_i,
  input  srrw_pkg::slot_t             fill_i,
  input  logic                        fill_sel_i,
  input  logic [srrw_pkg::SEQ_W-1:0]  key_i,
  input  logic                        prior_i,
  output srrw_pkg::slot_t             slot_o,
  output logic                        first_o,
  output logic                        prior_o
);
  import srrw_pkg::*;

  slot_t slot_q, slot_d;
  logic  match;

  assign match   = slot_q.valid && (slot_q.seq == key_i);
  assign first_o = match && !prior_i;
  assign prior_o = prior_i || match;
  assign slot_o  = slot_q;

  always_comb begin
    slot_d = slot_q;
    priority if (ctl_i.restart) begin
      slot_d = init_i;
    end else if (ctl_i.shift) begin
      slot_d = fill_sel_i ? fill_i : next_i;
    end else if (ctl_i.mark && first_o) begin
      slot_d.acked = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else begin
      slot_q <= slot_d;
    end
  end

endmodule

// ===== sv/selective_repeat_receiver_window.sv =====
`timescale 1ns / 1ps

// Selective-repeat receive window.
// in_i carries one packet event per request (kind: intact or corrupted,
// seq_num). out_o returns one reply per request: reply code, reply_seq,
// the number of slots released by the slide, and the all-received flag.
// The APB port holds window_size (0x0) and total_packets (0x4); any write
// restarts the transfer in the following cycle, during which no request
// is taken.
// After accept, a request passes the states EVAL, HIST (window miss only),
// SLIDE (one left shift of the cell row per released slot) and DONE, which
// loads out_o. A packet that misses the window walks the history range
// one packet index per cycle.
// One request is in flight at a time; the next one is accepted once the
// result sits in the output register.
// Reset empties the window cells and loads the reset register values
// (window 15, no packets); the out_o data fields are not reset. When
// out_o stalls, the finished result holds in the output register, one
// more request is taken and worked, and its result waits until the
// register frees up.
module selective_repeat_receiver_window (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  srrw_in_if.sink                      in_i,
  srrw_out_if.source                   out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [srrw_pkg::ADDR_W-1:0]  paddr,
  input  logic [srrw_pkg::DATA_W-1:0]  pwdata,
  output logic [srrw_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);
  import srrw_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EVAL  = 3'd1;
  localparam logic [2:0] S_HIST  = 3'd2;
  localparam logic [2:0] S_SLIDE = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  cfg_t            cfg;
  cell_ctl_t       ctl;
  slot_t           slot [WINDOW_MAX];
  slot_t           init [WINDOW_MAX];
  slot_t           fill;
  logic [WINDOW_MAX-1:0] first;
  logic [WINDOW_MAX:0]   prior;
  logic [WIN_W-1:0]      w_act;

  logic [2:0]         state_q, state_d;
  logic               kind_q, kind_d;
  logic [SEQ_W-1:0]   seq_q, seq_d;
  reply_e             reply_q, reply_d;
  logic [IDX_W-1:0]   k_q, k_d;
  logic [IDX_W-1:0]   hi_q, hi_d;
  logic [SEQ_W-1:0]   hseq_q, hseq_d;
  logic [WIN_W-1:0]   rel_q, rel_d;
  logic [IDX_W-1:0]   next_idx_q, next_idx_d;
  logic [SEQ_W-1:0]   next_seq_q, next_seq_d;
  logic [IDX_W-1:0]   acked_cnt_q, acked_cnt_d;

  logic               out_valid_q, out_valid_d;
  logic [REPLY_W-1:0] out_reply_q, out_reply_d;
  logic [SEQ_W-1:0]   out_seq_q, out_seq_d;
  logic [REL_W-1:0]   out_rel_q, out_rel_d;
  logic               out_all_q, out_all_d;

  logic               hit_any, hit_acked, do_shift, fill_ok;
  logic [IDX_W-1:0]   lo, hi;
  logic [SEQ_W-1:0]   lo_seq;
  logic [SEQ_W:0]     back_diff;

  srrw_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign w_act    = active_window(cfg.window_size);
  assign fill_ok  = next_idx_q < cfg.total_packets;
  assign fill     = '{valid: fill_ok, acked: 1'b0, seq: fill_ok ? next_seq_q : '0};
  assign do_shift = slot[0].valid && slot[0].acked;
  assign prior[0] = 1'b0;

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    slot_t nxt;
    if (i == WINDOW_MAX - 1) begin : g_last
      assign nxt = '0;
    end else begin : g_mid
      assign nxt = slot[i+1];
    end
    assign init[i] = '{valid: (WIN_W'(i) < w_act) && (IDX_W'(i) < cfg.total_packets),
                       acked: 1'b0, seq: SEQ_TAB[i]};
    srrw_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .init_i     (init[i]),
      .next_i     (nxt),
      .fill_i     (fill),
      .fill_sel_i (WIN_W'(i) == (w_act - WIN_W'(1))),
      .key_i      (seq_q),
      .prior_i    (prior[i]),
      .slot_o     (slot[i]),
      .first_o    (first[i]),
      .prior_o    (prior[i+1])
    );
  end

  assign hit_any = prior[WINDOW_MAX];

  always_comb begin
    hit_acked = 1'b0;
    for (int i = 0; i < WINDOW_MAX; i++) begin
      hit_acked = hit_acked || (first[i] && slot[i].acked);
    end
  end

  always_comb begin
    lo        = (next_idx_q > IDX_W'(HIST_SPAN)) ? next_idx_q - IDX_W'(HIST_SPAN) : '0;
    hi        = fill_ok ? next_idx_q : cfg.total_packets;
    back_diff = {1'b0, next_seq_q} - (SEQ_W+1)'(HIST_BACK);
    if (back_diff[SEQ_W]) begin
      back_diff = back_diff + (SEQ_W+1)'(SEQ_MODULUS);
    end
    lo_seq = (next_idx_q > IDX_W'(HIST_SPAN)) ? back_diff[SEQ_W-1:0] : '0;
  end

  assign ctl = '{restart: cfg.restart,
                 shift:   (state_q == S_SLIDE) && do_shift,
                 mark:    (state_q == S_EVAL) && !kind_q};

  assign in_i.ready = (state_q == S_IDLE) && !cfg.restart;

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    seq_d       = seq_q;
    reply_d     = reply_q;
    k_d         = k_q;
    hi_d        = hi_q;
    hseq_d      = hseq_q;
    rel_d       = rel_q;
    next_idx_d  = next_idx_q;
    next_seq_d  = next_seq_q;
    acked_cnt_d = acked_cnt_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_reply_d = out_reply_q;
    out_seq_d   = out_seq_q;
    out_rel_d   = out_rel_q;
    out_all_d   = out_all_q;

    if (cfg.restart) begin
      next_idx_d  = IDX_W'(w_act);
      next_seq_d  = SEQ_TAB[w_act];
      acked_cnt_d = '0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid && in_i.ready) begin
          kind_d  = in_i.kind;
          seq_d   = in_i.seq_num;
          rel_d   = '0;
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        state_d = S_SLIDE;
        if (kind_q) begin
          reply_d = (hit_any && !hit_acked) ? REPLY_RETX : REPLY_NONE;
        end else if (hit_any) begin
          reply_d = REPLY_ACK;
          if (!hit_acked && (acked_cnt_q != '1)) begin
            acked_cnt_d = acked_cnt_q + IDX_W'(1);
          end
        end else begin
          k_d     = lo;
          hi_d    = hi;
          hseq_d  = lo_seq;
          state_d = S_HIST;
        end
      end
      S_HIST: begin
        if (k_q >= hi_q) begin
          reply_d = REPLY_NONE;
          state_d = S_SLIDE;
        end else if (hseq_q == seq_q) begin
          reply_d = REPLY_ACK;
          state_d = S_SLIDE;
        end else begin
          k_d    = k_q + IDX_W'(1);
          hseq_d = seq_advance(hseq_q);
        end
      end
      S_SLIDE: begin
        if (do_shift) begin
          rel_d = rel_q + WIN_W'(1);
          if (fill_ok) begin
            next_idx_d = next_idx_q + IDX_W'(1);
            next_seq_d = seq_advance(next_seq_q);
          end
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_reply_d = reply_q;
          out_seq_d   = (reply_q != REPLY_NONE) ? seq_q : '0;
          out_rel_d   = REL_W'(rel_q);
          out_all_d   = acked_cnt_q >= cfg.total_packets;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      next_idx_q  <= IDX_W'(WS_RESET_ACT);
      next_seq_q  <= SEQ_TAB[WS_RESET_ACT];
      acked_cnt_q <= '0;
      rel_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      next_idx_q  <= next_idx_d;
      next_seq_q  <= next_seq_d;
      acked_cnt_q <= acked_cnt_d;
      rel_q       <= rel_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q      <= kind_d;
    seq_q       <= seq_d;
    reply_q     <= reply_d;
    k_q         <= k_d;
    hi_q        <= hi_d;
    hseq_q      <= hseq_d;
    out_reply_q <= out_reply_d;
    out_seq_q   <= out_seq_d;
    out_rel_q   <= out_rel_d;
    out_all_q   <= out_all_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.reply        = out_reply_q;
  assign out_o.reply_seq    = out_seq_q;
  assign out_o.released     = out_rel_q;
  assign out_o.all_received = out_all_q;

endmodule
